@@ design/projection_profile_histogram_top_defines.svh @@
// Assertion macros for the projection profile histogram.
`ifndef PROJECTION_PROFILE_HISTOGRAM_TOP_DEFINES_SVH
`define PROJECTION_PROFILE_HISTOGRAM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PPH_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PPH_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define PPH_ASSERT(lbl, prop, msg)
`define PPH_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

@@ design/pph_pkg.sv @@
package pph_pkg;

  localparam int BINS        = 8192;
  localparam int COUNT_BITS  = 24;
  localparam int COORD_BITS  = 12;

  localparam int IN_COORD_W  = 12;
  localparam int SEL_W       = 13;
  localparam int COEF_W      = 16;
  localparam int OFFSET_W    = 14;
  localparam int THR_W       = 8;
  localparam int FRAC_BITS   = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int OP_W        = 2;

  localparam int IDX_W       = $clog2(BINS);
  localparam int PROD_W      = COEF_W + COORD_BITS + 1;
  localparam int SUM_W       = PROD_W + 1;
  localparam int P_W         = SUM_W - FRAC_BITS;
  localparam int CALC_A      = (P_W > OFFSET_W) ? P_W : OFFSET_W;
  localparam int CALC_B      = (CALC_A > IDX_W + 1) ? CALC_A : IDX_W + 1;
  localparam int CALC_W      = CALC_B + 1;
  localparam int BIN_W       = (IDX_W > SEL_W) ? IDX_W : SEL_W;
  localparam int SELCMP_W    = (SEL_W > IDX_W + 1) ? SEL_W : IDX_W + 1;
  localparam int FRAC_MASK   = (1 << FRAC_BITS) - 1;

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  localparam logic signed [COEF_W-1:0]   COS_RST    = COEF_W'(16384);
  localparam logic signed [COEF_W-1:0]   SIN_RST    = '0;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = '0;
  localparam logic [THR_W-1:0]           THR_RST    = THR_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL      = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS       = 3'd0,
    REG_SIN       = 3'd1,
    REG_OFFSET    = 3'd2,
    REG_THRESHOLD = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    K_ZERO,
    K_PIX_OOR,
    K_INC,
    K_READ,
    K_CLEAR,
    K_READ_OOR
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [BIN_W-1:0] bin;
  } q_entry_t;

endpackage

@@ design/pph_front.sv @@
module pph_front import pph_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEF_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [IN_COORD_W-1:0] col_i,
  input  logic [IN_COORD_W-1:0] row_i,
  input  logic [THR_W-1:0]      pixel_value_i,
  input  logic [SEL_W-1:0]      bin_select_i,
  input  logic                  clearing_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output q_entry_t              q_entry_o
);

  localparam logic signed [CALC_W-1:0] BINS_C = CALC_W'(BINS);

  logic signed [COEF_W-1:0]   cos_q, sin_q;
  logic signed [OFFSET_W-1:0] offset_q;
  logic [THR_W-1:0]           thr_q;

  logic                     en, acc;
  logic [COORD_BITS-1:0]    col_c, row_c;

  logic                     s1_valid_q, s2_valid_q, s3_valid_q;
  logic [OP_W-1:0]          s1_op_q, s2_op_q, s3_op_q;
  logic                     s1_hit_q, s2_hit_q, s3_hit_q;
  logic [SEL_W-1:0]         s1_sel_q, s2_sel_q, s3_sel_q;
  logic signed [PROD_W-1:0] s1_pc_q, s1_pr_q;
  logic signed [SUM_W-1:0]  s2_sum_q, s2_biased;
  logic signed [P_W-1:0]    s3_p_q;
  logic signed [CALC_W-1:0] bin_calc;
  logic                     pix_oor, sel_oor;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= COS_RST;
      sin_q    <= SIN_RST;
      offset_q <= OFFSET_RST;
      thr_q    <= THR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COS:       cos_q    <= cfg_data_i;
        REG_SIN:       sin_q    <= cfg_data_i;
        REG_OFFSET:    offset_q <= cfg_data_i[OFFSET_W-1:0];
        REG_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !(s3_valid_q && q_full_i);
  assign in_ready_o = en && !clearing_i;
  assign acc        = in_valid_i && in_ready_o;
  assign col_c      = COORD_BITS'(col_i);
  assign row_c      = COORD_BITS'(row_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign s2_biased = s2_sum_q + (s2_sum_q[SUM_W-1] ? SUM_W'(FRAC_MASK) : SUM_W'(0));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q  <= operation_i;
      s1_hit_q <= pixel_value_i > thr_q;
      s1_sel_q <= bin_select_i;
      s1_pc_q  <= cos_q * $signed({1'b0, col_c});
      s1_pr_q  <= sin_q * $signed({1'b0, row_c});
      s2_op_q  <= s1_op_q;
      s2_hit_q <= s1_hit_q;
      s2_sel_q <= s1_sel_q;
      s2_sum_q <= SUM_W'(s1_pc_q) + SUM_W'(s1_pr_q);
      s3_op_q  <= s2_op_q;
      s3_hit_q <= s2_hit_q;
      s3_sel_q <= s2_sel_q;
      s3_p_q   <= s2_biased[SUM_W-1:FRAC_BITS];
    end
  end

  assign bin_calc = CALC_W'(s3_p_q) - CALC_W'(offset_q);
  assign pix_oor  = (bin_calc < 0) || (bin_calc >= BINS_C);
  assign sel_oor  = SELCMP_W'(s3_sel_q) >= SELCMP_W'(BINS);

  always_comb begin
    q_entry_o.kind = K_ZERO;
    q_entry_o.bin  = '0;
    unique case (s3_op_q) inside
      OP_PIXEL: begin
        if (s3_hit_q && pix_oor) begin
          q_entry_o.kind = K_PIX_OOR;
        end else if (s3_hit_q) begin
          q_entry_o.kind = K_INC;
          q_entry_o.bin  = BIN_W'(bin_calc[IDX_W-1:0]);
        end
      end
      OP_READ, OP_READ_CLEAR: begin
        q_entry_o.bin = BIN_W'(s3_sel_q);
        if (sel_oor) begin
          q_entry_o.kind = K_READ_OOR;
        end else if (s3_op_q == OP_READ) begin
          q_entry_o.kind = K_READ;
        end else begin
          q_entry_o.kind = K_CLEAR;
        end
      end
      default: ;
    endcase
  end

  assign q_push_o = s3_valid_q && !q_full_i;

endmodule

@@ design/pph_queue.sv @@
module pph_queue import pph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t head_o
);

  q_entry_t             entries_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]     cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == (Q_PTR_W + 1)'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ design/pph_back.sv @@
module pph_back import pph_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q_entry_t              head_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SEL_W-1:0]      bin_index_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  counted_o,
  output logic                  out_of_range_o
);

  logic [COUNT_BITS-1:0] mem_q [BINS];
  logic [COUNT_BITS-1:0] rdata_q;

  logic                  clr_q;
  logic [IDX_W-1:0]      clr_addr_q;

  logic                  b1_valid_q;
  q_entry_t              b1_entry_q;
  logic [IDX_W-1:0]      b1_addr, rd_addr;

  logic                  lw_valid_q;
  logic [IDX_W-1:0]      lw_addr_q;
  logic [COUNT_BITS-1:0] lw_data_q;

  logic                  load, en;
  logic [COUNT_BITS-1:0] cur;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;
  logic [SEL_W-1:0]      res_bin;
  logic [COUNT_BITS-1:0] res_count;
  logic                  res_counted, res_oor;

  logic                  out_valid_q;
  logic [SEL_W-1:0]      out_bin_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic                  out_counted_q, out_oor_q;

  assign clearing_o = clr_q;
  assign rd_addr    = head_i.bin[IDX_W-1:0];
  assign b1_addr    = b1_entry_q.bin[IDX_W-1:0];
  assign load       = b1_valid_q && (!out_valid_q || out_ready_i);
  assign en         = !b1_valid_q || load;
  assign q_pop_o    = en && !q_empty_i && !clr_q;
  assign cur        = (lw_valid_q && lw_addr_q == b1_addr) ? lw_data_q : rdata_q;

  always_comb begin
    wr_en       = 1'b0;
    wr_data     = '0;
    res_bin     = '0;
    res_count   = '0;
    res_counted = 1'b0;
    res_oor     = 1'b0;
    unique case (b1_entry_q.kind)
      K_ZERO: ;
      K_PIX_OOR: res_oor = 1'b1;
      K_INC: begin
        wr_en       = 1'b1;
        wr_data     = (cur == '1) ? cur : cur + COUNT_BITS'(1);
        res_bin     = b1_entry_q.bin[SEL_W-1:0];
        res_count   = wr_data;
        res_counted = 1'b1;
      end
      K_READ: begin
        res_bin   = b1_entry_q.bin[SEL_W-1:0];
        res_count = cur;
      end
      K_CLEAR: begin
        wr_en     = 1'b1;
        res_bin   = b1_entry_q.bin[SEL_W-1:0];
        res_count = cur;
      end
      K_READ_OOR: begin
        res_bin = b1_entry_q.bin[SEL_W-1:0];
        res_oor = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (load && wr_en) begin
      mem_q[b1_addr] <= wr_data;
    end
    if (q_pop_o) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      b1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_addr_q == IDX_W'(BINS - 1)) begin
          clr_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (en) begin
        b1_valid_q <= q_pop_o;
        lw_valid_q <= load && wr_en;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_entry_q <= head_i;
      lw_addr_q  <= b1_addr;
      lw_data_q  <= wr_data;
    end
    if (load) begin
      out_bin_q     <= res_bin;
      out_count_q   <= res_count;
      out_counted_q <= res_counted;
      out_oor_q     <= res_oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bin_index_o    = out_bin_q;
  assign count_o        = out_count_q;
  assign counted_o      = out_counted_q;
  assign out_of_range_o = out_oor_q;

endmodule

@@ design/projection_profile_histogram_top.sv @@
// Projection profile histogram. Each pixel beat above the threshold is projected as
// col*cos + row*sin (Q2.14 coefficients, truncated toward zero), shifted by the bin
// offset and counted in a saturating 8192-bin histogram; read and read-and-clear beats
// return one bin. Every input beat yields exactly one result beat. The block sustains one
// beat per cycle when the output is not stalled: a three-stage front (multiply, sum,
// truncate) classifies each beat, a four-entry queue decouples it from the back end, whose
// one-read one-write histogram memory does one read-modify-write per cycle with forwarding
// of the previous write. After reset the histogram is swept to zero; in_ready_o stays low
// until that ends, while configuration writes are taken at any time.
`include "projection_profile_histogram_top_defines.svh"

module projection_profile_histogram_top import pph_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEF_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [IN_COORD_W-1:0] col_i,
  input  logic [IN_COORD_W-1:0] row_i,
  input  logic [THR_W-1:0]      pixel_value_i,
  input  logic [SEL_W-1:0]      bin_select_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SEL_W-1:0]      bin_index_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  counted_o,
  output logic                  out_of_range_o
);

  logic     clearing;
  logic     q_full, q_push, q_pop, q_empty;
  q_entry_t q_entry, q_head;

  pph_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .pixel_value_i (pixel_value_i),
    .bin_select_i  (bin_select_i),
    .clearing_i    (clearing),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_entry)
  );

  pph_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  pph_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bin_index_o    (bin_index_o),
    .count_o        (count_o),
    .counted_o      (counted_o),
    .out_of_range_o (out_of_range_o)
  );

  `PPH_ASSERT(a_no_accept_clr, !(in_valid_i && in_ready_o && clearing), "beat during clear sweep")
  `PPH_ASSERT_IMPL(a_cnt_oor_excl, out_valid_o, !(counted_o && out_of_range_o), "counted with oor")
  `PPH_ASSERT_IMPL(a_counted_nz, out_valid_o && counted_o, count_o != '0, "zero count on counted")
  `PPH_ASSERT_IMPL(a_oor_zero, out_valid_o && out_of_range_o, count_o == '0, "out of range with count")

endmodule
